// ===== rtl/lattice_move_legality_check_core_macros.svh =====
`ifndef LATTICE_MOVE_LEGALITY_CHECK_CORE_MACROS_SVH
`define LATTICE_MOVE_LEGALITY_CHECK_CORE_MACROS_SVH

// Same-cycle implication, checked on clk outside reset
`define LMLC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset
`define LMLC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lmlc_pkg.sv =====
package lmlc_pkg;

  // Sizing defaults
  localparam int MAX_SIDE_DEF = 64;
  localparam int MAX_MONOMERS = 1024;
  localparam int Q_DEPTH_DEF  = 2;
  localparam int BOND_LIMIT   = 13;

  // Register reset values
  localparam logic [6:0]  SIDE_RST  = 7'd64;
  localparam logic [10:0] CHAIN_RST = 11'(MAX_MONOMERS);

  // Register indexes
  localparam logic REG_SIDE  = 1'b0;
  localparam logic REG_CHAIN = 1'b1;

  // Request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // Signed lattice coordinate, wide enough for one step off either edge
  typedef logic signed [7:0] coord_t;

  // One classified transaction waiting for the back end
  typedef struct packed {
    logic       is_check;
    logic       wr_value;
    coord_t     tr;         // target row, or row to write
    coord_t     tc;         // target column, or column to write
    logic [8:0] cell_mask;  // neighborhood cells to test, row-major
    logic       pre_ok;     // target inside lattice and both bonds short
  } lmlc_item_t;

  // Row offset of a move code
  function automatic coord_t move_dr(input logic [2:0] mc);
    coord_t d;
    unique case (mc)
      3'd0, 3'd1, 3'd2: d = -8'sd1;
      3'd3, 3'd4:       d = 8'sd0;
      3'd5, 3'd6, 3'd7: d = 8'sd1;
    endcase
    return d;
  endfunction

  // Column offset of a move code
  function automatic coord_t move_dc(input logic [2:0] mc);
    coord_t d;
    unique case (mc)
      3'd0, 3'd3, 3'd5: d = -8'sd1;
      3'd1, 3'd6:       d = 8'sd0;
      3'd2, 3'd4, 3'd7: d = 8'sd1;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/lmlc_front.sv =====
module lmlc_front import lmlc_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic        req_type,
  input  logic [9:0]  monomer_index,
  input  logic [2:0]  move_code,
  input  logic [5:0]  cur_row,
  input  logic [5:0]  cur_col,
  input  logic [5:0]  prev_row,
  input  logic [5:0]  prev_col,
  input  logic [5:0]  next_row,
  input  logic [5:0]  next_col,
  input  logic        cell_value,
  input  logic [6:0]  lattice_side,
  input  logic [10:0] chain_length,
  output lmlc_item_t  item,
  output logic        keep
);

  localparam logic [8:0] SIDE_LIM = 9'(MAX_SIDE);

  logic [8:0]  side;
  logic [10:0] last_idx;
  coord_t      dr, dc, tr, tc, cr, cc;
  logic        is_check, wr_in, inbound, prev_ok, next_ok;
  logic [8:0]  mask;

  // Coordinate lies in 0 .. s-1
  function automatic logic in_side(input coord_t x, input logic [8:0] s);
    return !x[7] && ({1'b0, x} < s);
  endfunction

  // Squared bond length within limit
  function automatic logic bond_ok(input coord_t t_r, input coord_t t_c,
                                   input logic [5:0] r, input logic [5:0] c);
    coord_t             d_r, d_c;
    logic signed [15:0] s_r, s_c;
    logic signed [16:0] s;
    d_r = t_r - $signed({2'b00, r});
    d_c = t_c - $signed({2'b00, c});
    s_r = 16'(d_r) * 16'(d_r);
    s_c = 16'(d_c) * 16'(d_c);
    s   = {s_r[15], s_r} + {s_c[15], s_c};
    return s <= 17'(BOND_LIMIT);
  endfunction

  // Effective side, capped by storage
  assign side = ({2'b00, lattice_side} > SIDE_LIM) ? SIDE_LIM : {2'b00, lattice_side};
  assign last_idx = chain_length - 11'd1;

  // Target position
  assign dr = move_dr(move_code);
  assign dc = move_dc(move_code);
  assign cr = $signed({2'b00, cur_row});
  assign cc = $signed({2'b00, cur_col});
  assign tr = cr + dr;
  assign tc = cc + dc;

  // Neighborhood mask: inside lattice, source cell excluded
  always_comb begin
    mask = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mask[i*3+j] = in_side(tr + coord_t'(i - 1), side) &&
                      in_side(tc + coord_t'(j - 1), side) &&
                      !((coord_t'(i - 1) == -dr) && (coord_t'(j - 1) == -dc));
      end
    end
  end

  // Bounds and bond checks
  assign inbound = in_side(tr, side) && in_side(tc, side);
  assign prev_ok = (monomer_index == 10'd0) || bond_ok(tr, tc, prev_row, prev_col);
  assign next_ok = ({1'b0, monomer_index} == last_idx) ||
                   bond_ok(tr, tc, next_row, next_col);

  // Classification
  assign is_check = (req_type == REQ_CHECK);
  assign wr_in    = (req_type == REQ_WRITE) &&
                    ({3'b000, cur_row} < SIDE_LIM) && ({3'b000, cur_col} < SIDE_LIM);
  assign keep     = is_check || wr_in;

  assign item.is_check  = is_check;
  assign item.wr_value  = cell_value;
  assign item.tr        = is_check ? tr : cr;
  assign item.tc        = is_check ? tc : cc;
  assign item.cell_mask = mask;
  assign item.pre_ok    = inbound && prev_ok && next_ok;

endmodule

// ===== rtl/lmlc_queue.sv =====
module lmlc_queue import lmlc_pkg::*; #(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lmlc_item_t din,
  input  logic       pop,
  output lmlc_item_t dout,
  output logic       full,
  output logic       empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  lmlc_item_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= next_ptr(wr_ptr_r);
      if (pop)  rd_ptr_r <= next_ptr(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ===== rtl/lmlc_back.sv =====
module lmlc_back import lmlc_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  lmlc_item_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_move_legal,
  output logic [5:0] out_target_row,
  output logic [5:0] out_target_col
);

  localparam int ROW_W = $clog2(MAX_SIDE);
  localparam logic [8:0] SIDE_LIM = 9'(MAX_SIDE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  typedef logic [ROW_W-1:0] ridx_t;

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] row_vld_r;
  logic [MAX_SIDE-1:0] rd_row_r;
  logic [MAX_SIDE-1:0] wr_row;
  logic [2:0]          state_r, state_nxt;
  lmlc_item_t          work_r, work_nxt;
  logic                hit_r, hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                legal_r;
  logic [5:0]          trow_r, tcol_r;
  coord_t              rd_coord;
  logic                rd_ok, wr_en, dec_fire, legal, out_ready;
  ridx_t               rd_idx, wr_idx, wr_col;
  logic [2:0]          win;

  function automatic logic coord_ok(input coord_t x);
    return !x[7] && ({1'b0, x} < SIDE_LIM);
  endfunction

  // Three cells of a row around a column
  function automatic logic [2:0] window(input logic [MAX_SIDE-1:0] row, input coord_t c);
    logic [2:0] w;
    coord_t     k;
    w = '0;
    for (int j = 0; j < 3; j++) begin
      k    = c + coord_t'(j - 1);
      w[j] = coord_ok(k) ? row[ridx_t'(k)] : 1'b0;
    end
    return w;
  endfunction

  // Row address for the single read port
  always_comb begin
    unique case (state_r)
      S_IDLE:       rd_coord = q_head.is_check ? q_head.tr - 8'sd1 : q_head.tr;
      S_RD1:        rd_coord = work_r.tr;
      S_RD2, S_DEC: rd_coord = work_r.tr + 8'sd1;
      S_WR:         rd_coord = work_r.tr;
      default:      rd_coord = work_r.tr;
    endcase
  end

  assign rd_ok     = coord_ok(rd_coord);
  assign rd_idx    = ridx_t'(rd_coord);
  assign wr_idx    = ridx_t'(work_r.tr);
  assign wr_col    = ridx_t'(work_r.tc);
  assign win       = window(rd_row_r, work_r.tc);
  assign out_ready = !out_valid_r || !out_stall;
  assign legal     = work_r.pre_ok && !(hit_r || |(win & work_r.cell_mask[8:6]));

  // Read-modify-write data for a cell write
  always_comb begin
    wr_row         = rd_row_r;
    wr_row[wr_col] = work_r.wr_value;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    work_nxt  = work_r;
    hit_nxt   = hit_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    dec_fire  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          work_nxt  = q_head;
          hit_nxt   = 1'b0;
          state_nxt = q_head.is_check ? S_RD1 : S_WR;
        end
      end
      S_RD1: begin
        hit_nxt   = |(win & work_r.cell_mask[2:0]);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        hit_nxt   = hit_r || |(win & work_r.cell_mask[5:3]);
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (out_ready) begin
          dec_fire  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WR: begin
        wr_en     = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output slot: held while stalled, freed when taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (dec_fire) out_valid_nxt = 1'b1;
  end

  // Control state and row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) row_vld_r[wr_idx] <= 1'b1;
    end
  end

  // Lattice rows; a row never written reads empty
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_row;
    rd_row_r <= (rd_ok && row_vld_r[rd_idx]) ? mem[rd_idx] : '0;
  end

  // Working item and result payload
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    hit_r  <= hit_nxt;
    if (dec_fire) begin
      legal_r <= legal;
      trow_r  <= legal ? work_r.tr[5:0] : 6'd0;
      tcol_r  <= legal ? work_r.tc[5:0] : 6'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_move_legal = legal_r;
  assign out_target_row = trow_r;
  assign out_target_col = tcol_r;

endmodule

// ===== rtl/lattice_move_legality_check_core.sv =====
// Move legality checker for a polymer on a square occupancy lattice. A write
// transaction (req_type 0) sets or clears one cell and gives no result; a check
// transaction (req_type 1) gives one result: move_legal, and the target
// position when legal (zero otherwise). Inputs are classified at once and
// parked in a short queue, so a new transaction is taken every cycle while the
// queue has room. The back end owns the single-port lattice memory: a check
// does three row reads for the 3x3 neighborhood, then the decision (held while
// the result slot is stalled); a write reads the row and writes it back. It
// starts a transaction only after the last is done, on its one read port. The
// lattice is empty right after reset: per-row valid bits clear at once, with
// no clearing pass. Registers: lattice_side at byte 0, chain_length at byte 4;
// write them only while the block is idle.
`include "lattice_move_legality_check_core_macros.svh"

module lattice_move_legality_check_core import lmlc_pkg::*; #(
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [9:0]  in_monomer_index,
  input  logic [2:0]  in_move_code,
  input  logic [5:0]  in_cur_row,
  input  logic [5:0]  in_cur_col,
  input  logic [5:0]  in_prev_row,
  input  logic [5:0]  in_prev_col,
  input  logic [5:0]  in_next_row,
  input  logic [5:0]  in_next_col,
  input  logic        in_cell_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_move_legal,
  output logic [5:0]  out_target_row,
  output logic [5:0]  out_target_col,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]  lattice_side_r;
  logic [10:0] chain_length_r;
  logic        cfg_wr;
  lmlc_item_t  f_item, q_head;
  logic        f_keep, q_push, q_pop, q_full, q_empty;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lattice_side_r <= SIDE_RST;
      chain_length_r <= CHAIN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SIDE:  lattice_side_r <= pwdata[6:0];
        REG_CHAIN: chain_length_r <= pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SIDE:  prdata = {25'd0, lattice_side_r};
      REG_CHAIN: prdata = {21'd0, chain_length_r};
    endcase
  end

  // Front end: classify each transaction
  lmlc_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .req_type      (in_req_type),
    .monomer_index (in_monomer_index),
    .move_code     (in_move_code),
    .cur_row       (in_cur_row),
    .cur_col       (in_cur_col),
    .prev_row      (in_prev_row),
    .prev_col      (in_prev_col),
    .next_row      (in_next_row),
    .next_col      (in_next_col),
    .cell_value    (in_cell_value),
    .lattice_side  (lattice_side_r),
    .chain_length  (chain_length_r),
    .item          (f_item),
    .keep          (f_keep)
  );

  // Writes outside storage are dropped here
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && f_keep;

  lmlc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_item),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back end: lattice memory and decision
  lmlc_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_move_legal (out_move_legal),
    .out_target_row (out_target_row),
    .out_target_col (out_target_col)
  );

  // Assertions
  `LMLC_ASSERT_NEXT(a_push_lands, q_push, !q_empty, "queued transaction lost")
  `LMLC_ASSERT_IMPL(a_illegal_zero, out_valid && !out_move_legal, (out_target_row == 6'd0) && (out_target_col == 6'd0), "illegal result carries a target")
  `LMLC_ASSERT_IMPL(a_legal_inside, out_valid && out_move_legal, ({1'b0, out_target_row} < lattice_side_r) && ({1'b0, out_target_col} < lattice_side_r), "legal target outside lattice")

endmodule
